/* sv/lphs_pkg.sv */
// Package for the linear probing hash set.
// Holds the operation and status codes and the control bundle sent to the slot cells.
// No dependencies.
`default_nettype none

package lphs_pkg;

    localparam int KEY_W      = 31;
    localparam int HOME_W     = 8;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_DELETE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic              start;
        logic              run;
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [HOME_W-1:0] home;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* sv/linear_probe_hash_set_top.sv */
// Flow: the key is multiplied by the slot count's reciprocal at accept, S_MOD reduces it
// to its home slot, then S_WALK probes one slot per cycle (1 to SLOTS slots) until a hit or the last slot.
// One operation is in flight at a time; the next beat is taken once the result is registered,
// even while that result waits to be taken; a stalled output first parks the result in S_HOLD.
// Synchronous active-low reset empties the table and clears all handshake state.
// Top level of the hash set; depends on lphs_pkg and lphs_cell.
`default_nettype none

module linear_probe_hash_set_top
    import lphs_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_kind,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_status
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LOG_S = $clog2(SLOTS);
    localparam int SH    = KEY_W + LOG_S;
    localparam int PW    = 2 * KEY_W + 1;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [KEY_W:0]   RECIP     = RECIP_WIDE[KEY_W:0];
    localparam logic [KEY_W-1:0] SLOTS_K   = KEY_W'(SLOTS);
    localparam logic [IW-1:0]    LAST_STEP = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_WALK = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [1:0]            r_kind;
    logic [KEY_W-1:0]      r_key;
    logic [PW-1:0]         r_prod;
    logic [IW-1:0]         r_step;
    logic [1:0]            r_pend;
    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [PW-1-SH:0]      quot;
    logic [KEY_W-1:0]      quot_x;
    logic [KEY_W-1:0]      rem_key;
    logic                  in_acc;
    logic                  out_free;
    logic                  walk_end;
    logic                  any_hit;
    logic [1:0]            fin_status;
    t_cell_ctl             ctl;
    logic [SLOTS-1:0]      tok;
    logic [SLOTS-1:0]      hit;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign any_hit  = |hit;
    assign walk_end = any_hit || (r_step == LAST_STEP);

    assign quot    = r_prod[PW-1:SH];
    assign quot_x  = KEY_W'(quot) * SLOTS_K;
    assign rem_key = r_key - quot_x;

    always_comb begin
        if (any_hit) begin
            fin_status = ST_OK;
        end else if (r_kind == KIND_INSERT) begin
            fin_status = ST_FULL;
        end else begin
            fin_status = ST_MISS;
        end
    end

    always_comb begin
        ctl.start = (r_state == S_MOD);
        ctl.run   = (r_state == S_WALK) && (r_step != LAST_STEP);
        ctl.kind  = r_kind;
        ctl.key   = r_key;
        ctl.home  = HOME_W'(rem_key);
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lphs_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   (tok[(g + SLOTS - 1) % SLOTS]),
            .o_tok   (tok[g]),
            .o_hit   (hit[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_MOD;
            S_MOD:  n_state = S_WALK;
            S_WALK: begin
                if (walk_end) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_WALK) && walk_end && out_free) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_HOLD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_prod <= PW'(i_key) * PW'(RECIP);
        end
        if (r_state == S_MOD) begin
            r_step <= '0;
        end else if (r_state == S_WALK) begin
            r_step <= r_step + 1'b1;
        end
        if ((r_state == S_WALK) && walk_end) begin
            if (out_free) begin
                r_status <= fin_status;
            end else begin
                r_pend <= fin_status;
            end
        end else if ((r_state == S_HOLD) && out_free) begin
            r_status <= r_pend;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

`default_nettype wire

/* sv/lphs_cell.sv */
// One slot of the hash set: stored key, occupancy bit and the probe token.
// Depends on lphs_pkg for the control bundle and the operation codes.
`default_nettype none

module lphs_cell
    import lphs_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_tok,
    output logic           o_tok,
    output logic           o_hit
);

    logic             r_tok;
    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic             n_tok;
    logic             cond;

    always_comb begin
        case (i_ctl.kind)
            KIND_INSERT: cond = !r_valid;
            KIND_SEARCH,
            KIND_DELETE: cond = r_valid && (r_key == i_ctl.key);
            default:     cond = 1'b0;
        endcase
    end

    assign o_hit = r_tok && cond;
    assign o_tok = r_tok && !cond;

    always_comb begin
        if (i_ctl.start) begin
            n_tok = (i_ctl.home == HOME_W'(IDX));
        end else if (i_ctl.run) begin
            n_tok = i_tok;
        end else begin
            n_tok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (o_hit && (i_ctl.kind == KIND_INSERT)) begin
                r_valid <= 1'b1;
            end else if (o_hit && (i_ctl.kind == KIND_DELETE)) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_hit && (i_ctl.kind == KIND_INSERT)) begin
            r_key <= i_ctl.key;
        end
    end

endmodule

`default_nettype wire

/* sv/lphs_checker.sv */
// Port-level checks for the hash set top level, bound to every instance of it.
// Depends on lphs_pkg for the status codes.
`default_nettype none

module lphs_checker
    import lphs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic [1:0]       i_kind,
    input wire logic [KEY_W-1:0] i_key,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [1:0]       o_status
);

    logic unused_ok;
    assign unused_ok = ^{i_kind, i_key};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result beat dropped before it was taken.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL))
        else $error("Result beat carries an undefined status.");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input taken again right after a beat.");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 !o_in_ready)
        else $error("Operation finished faster than the home slot reduction allows.");

endmodule

bind linear_probe_hash_set_top lphs_checker u_lphs_checker (.*);

`default_nettype wire
